FILE: hdl/imm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the integer matrix multiply unit.
// No dependencies; every other file of the block but imm_ram imports this package.
package imm_pkg;

	// default matrix dimension held by each store
	localparam int MAX_DIM_DEF = 16;

	// fixed widths of the item fields
	localparam int DATA_W = 32;
	localparam int IDX_FW = 4;
	localparam int CMD_W  = 2;
	localparam int CFG_W  = 5;
	localparam int CFG_IW = 2;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;

	// command codes carried on the input tuser
	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IW-1:0] REG_INNER  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_COLS_B = 2'd2;

	// register value after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_READ   = 2'd2,
		OP_OOB    = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [IDX_FW-1:0]  row;
		logic [IDX_FW-1:0]  col;
		logic [DATA_W-1:0]  value;
		logic [CFG_W-1:0]   nk;
	} op_t;

	// configuration register set
	typedef struct packed {
		logic [CFG_W-1:0] rows_a;
		logic [CFG_W-1:0] inner_size;
		logic [CFG_W-1:0] cols_b;
	} cfg_t;

endpackage

FILE: hdl/integer_matrix_multiply_unit.sv
`timescale 1ns / 1ps
// Integer matrix multiply unit: top level with configuration registers.
// Depends on imm_pkg, imm_front, imm_queue, imm_back (and through it imm_ram).
//
// Items on the slave stream either load one signed 32-bit element of matrix A
// or B (tuser 0 or 1) or request one element of A times B (tuser 2). Loads
// give no result; a load outside the store and tuser 3 are dropped at the
// front. A read inside the configured product size walks the inner dimension
// one multiply-accumulate per cycle through the single read port of each
// element store; a read outside the product size returns status 1 and value
// 0. A two-entry queue lets the front keep accepting while the back end
// works, and the result register lets the next item start while a result
// waits. The user must see that registers are written only while the unit
// is idle; the block does not enforce this. Values above MAX_DIM are used
// as MAX_DIM. Elements must be loaded before a read uses them.
module integer_matrix_multiply_unit import imm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // row_index[3:0], col_index[7:4], element_value[39:8]
	input  logic [CMD_W-1:0]  s_tuser,  // cmd[1:0]
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // product_value[31:0]
	output logic              m_tuser   // status[0]
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	op_t  push_op;
	logic pop;
	op_t  pop_op;
	logic q_not_empty;

	// write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_a     <= CFG_RESET;
			cfg_q.inner_size <= CFG_RESET;
			cfg_q.cols_b     <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A: cfg_q.rows_a     <= cfg_data;
				REG_INNER:  cfg_q.inner_size <= cfg_data;
				REG_COLS_B: cfg_q.cols_b     <= cfg_data;
				default:    cfg_q            <= cfg_q;
			endcase
		end
	end

	imm_front #(.MAX_DIM(MAX_DIM)) u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.cmd           (s_tuser),
		.row_index     (s_tdata[3:0]),
		.col_index     (s_tdata[7:4]),
		.element_value (s_tdata[39:8]),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.push          (push),
		.push_op       (push_op)
	);

	imm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (pop),
		.pop_op    (pop_op),
		.not_empty (q_not_empty)
	);

	imm_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (q_not_empty),
		.op            (pop_op),
		.op_pop        (pop),
		.product_value (m_tdata),
		.status        (m_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready)
	);

endmodule

FILE: hdl/imm_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one entry, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/imm_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified operations between the front and the back.
// Depends on imm_pkg for op_t and QDEPTH.
module imm_queue import imm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  pop_op,
	output logic not_empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	op_t           mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_op    = mem_q[rd_ptr_q];

	// store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/imm_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, checks them against the store size and
// the configured product size, and pushes classified operations. Uses imm_pkg.
module imm_front import imm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [IDX_FW-1:0] row_index,
	input  logic [IDX_FW-1:0] col_index,
	input  logic [DATA_W-1:0] element_value,
	input  cfg_t              cfg,
	input  logic              q_full,
	output logic              push,
	output op_t               push_op
);

	logic [CFG_W-1:0] nr;
	logic [CFG_W-1:0] nk;
	logic [CFG_W-1:0] nc;
	logic             in_store;
	logic             in_range;
	logic             keep;

	// saturate the registers to the store dimension
	always_comb begin
		nr = (int'(cfg.rows_a) > MAX_DIM)     ? CFG_W'(MAX_DIM) : cfg.rows_a;
		nk = (int'(cfg.inner_size) > MAX_DIM) ? CFG_W'(MAX_DIM) : cfg.inner_size;
		nc = (int'(cfg.cols_b) > MAX_DIM)     ? CFG_W'(MAX_DIM) : cfg.cols_b;
	end

	assign in_store = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign in_range = ({1'b0, row_index} < nr) && ({1'b0, col_index} < nc);

	// classify the item; drop loads outside the store and unused commands
	always_comb begin
		push_op.row   = row_index;
		push_op.col   = col_index;
		push_op.value = element_value;
		push_op.nk    = nk;
		push_op.kind  = OP_OOB;
		keep          = 1'b0;
		case (cmd)
			CMD_LOAD_A: begin
				push_op.kind = OP_LOAD_A;
				keep         = in_store;
			end
			CMD_LOAD_B: begin
				push_op.kind = OP_LOAD_B;
				keep         = in_store;
			end
			CMD_READ: begin
				push_op.kind = in_range ? OP_READ : OP_OOB;
				keep         = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full && keep;

endmodule

FILE: hdl/imm_back.sv
`timescale 1ns / 1ps
// Back end: executes loads into the two element stores and walks the inner
// dimension for product reads; holds the result register. Uses imm_pkg, imm_ram.
module imm_back import imm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  op_t               op,
	output logic              op_pop,
	output logic [DATA_W-1:0] product_value,
	output logic              status,
	output logic              m_tvalid,
	input  logic              m_tready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     a_addr_q;
	logic [AW-1:0]     b_addr_q;
	logic [CFG_W-1:0]  cnt_q;
	logic              v_s1, last_s1;
	logic              v_s2, last_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q;
	logic              out_v_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_status_q;

	logic              slot_free;
	logic [AW-1:0]     row_base;
	logic [AW-1:0]     wr_addr;
	logic              a_we, b_we;
	logic              issue;
	logic              start;
	logic              res_load;
	logic [DATA_W-1:0] res_data;
	logic              res_status;
	logic [DATA_W-1:0] a_rdata, b_rdata;

	assign slot_free = !out_v_q || m_tready;
	assign row_base  = AW'(op.row) * STRIDE;
	assign wr_addr   = row_base + AW'(op.col);
	assign issue     = (state_q == ST_ISSUE);

	// decide what the head operation does this cycle
	always_comb begin
		a_we       = 1'b0;
		b_we       = 1'b0;
		start      = 1'b0;
		op_pop     = 1'b0;
		res_load   = 1'b0;
		res_data   = acc_q;
		res_status = 1'b0;
		if (state_q == ST_IDLE && op_valid) begin
			case (op.kind)
				OP_LOAD_A: begin
					a_we   = 1'b1;
					op_pop = 1'b1;
				end
				OP_LOAD_B: begin
					b_we   = 1'b1;
					op_pop = 1'b1;
				end
				OP_READ: begin
					if (op.nk != '0) begin
						start  = 1'b1;
						op_pop = 1'b1;
					end else if (slot_free) begin
						res_load = 1'b1;
						res_data = '0;
						op_pop   = 1'b1;
					end
				end
				OP_OOB: begin
					if (slot_free) begin
						res_load   = 1'b1;
						res_data   = '0;
						res_status = 1'b1;
						op_pop     = 1'b1;
					end
				end
				default: begin
					op_pop = 1'b0;
				end
			endcase
		end else if (state_q == ST_DONE && slot_free) begin
			res_load = 1'b1;
		end
	end

	imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (wr_addr),
		.wdata (op.value),
		.re    (issue),
		.raddr (a_addr_q),
		.rdata (a_rdata)
	);

	imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (wr_addr),
		.wdata (op.value),
		.re    (issue),
		.raddr (b_addr_q),
		.rdata (b_rdata)
	);

	// sequence the read walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && (cnt_q == CFG_W'(1));
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= op.nk;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CFG_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (res_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// walk addresses, multiply, accumulate, hold the result
	always_ff @(posedge clk) begin
		if (start) begin
			a_addr_q <= row_base;
			b_addr_q <= AW'(op.col);
		end else if (issue) begin
			a_addr_q <= a_addr_q + 1'b1;
			b_addr_q <= b_addr_q + STRIDE;
		end
		prod_s2 <= a_rdata * b_rdata;
		if (start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
		if (res_load) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid      = out_v_q;
	assign product_value = out_data_q;
	assign status        = out_status_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> (state_q == ST_IDLE))
		else $error("queue popped outside idle");

	a_prod_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
		else $error("product term arrived outside a read walk");

	a_issue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (cnt_q != '0))
		else $error("issuing with no terms left");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!v_s1 && !v_s2))
		else $error("result taken before the pipeline drained");

endmodule
